// ===== hw/rtl/csvp_pkg.sv =====
// Shared constants for the CSV row length predictor: characters, alpha format, seeds.
`timescale 1ns / 1ps

package csvp_pkg;

  // Default geometry
  localparam int unsigned LENGTH_BITS_DEF   = 24;
  localparam int unsigned FIELD_BITS_DEF    = 16;
  localparam int unsigned COUNT_BITS_DEF    = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Byte stream
  localparam int unsigned BYTE_BITS = 8;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Smoothing factor, unsigned Q1.16 with one integer bit
  localparam int unsigned ALPHA_BITS  = 17;
  localparam int unsigned ALPHA_SHIFT = 16;
  localparam int unsigned ALPHA_HALF  = 32768;
  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE   = 17'h10000;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 17'd6554;

  // Prediction seeds after reset, integer part
  localparam int unsigned LENGTH_SEED = 100;
  localparam int unsigned FIELDS_SEED = 10;

endpackage

// ===== hw/rtl/csv_row_length_ewma_predictor.sv =====
// Top level of the CSV row length predictor: scanner, predictor, stream packing.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-----------------------------------------
//   s_*     | in  | s_tvalid_i/tready_o  | s_tdata_i = data_byte, s_tlast_i = end
//   m_*     | out | m_tvalid_o/tready_i  | m_tdata_o = one result per finished row
//   cfg_*   | in  | cfg_we_i             | cfg_wdata_i = smoothing_alpha
//
// One byte per cycle sustained while s_tready_o is high. A row result reaches
// m_tvalid_o from the byte that ends it through the row register, then the result
// register, which also takes the EWMA update. The update of each prediction is one
// alpha multiply in its own feedback loop, so a row may end on every byte. Reset
// takes effect at once, no clearing pass. While m_tready_i is low, one row and one
// result are held; s_tready_o drops only when both are full.
`timescale 1ns / 1ps

module csv_row_length_ewma_predictor #(
  parameter int unsigned LENGTH_BITS   = csvp_pkg::LENGTH_BITS_DEF,
  parameter int unsigned FIELD_BITS    = csvp_pkg::FIELD_BITS_DEF,
  parameter int unsigned COUNT_BITS    = csvp_pkg::COUNT_BITS_DEF,
  parameter int unsigned FRACTION_BITS = csvp_pkg::FRACTION_BITS_DEF,
  localparam int unsigned OUT_BITS = 2 * LENGTH_BITS + 2 * FIELD_BITS + 2 * FRACTION_BITS
                                     + 5 * COUNT_BITS + 3,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [csvp_pkg::ALPHA_BITS-1:0] cfg_wdata_i,  // smoothing_alpha
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [csvp_pkg::BYTE_BITS-1:0]  s_tdata_i,    // data_byte
  input  logic                            s_tlast_i,    // end_of_input
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  // row_length, row_fields, length_hit, fields_hit, realloc_needed, predicted_length,
  // predicted_fields, rows_seen, length_hits_total, fields_hits_total,
  // allocs_predicted, allocs_naive, zero fill
  output logic [OUT_W-1:0]                m_tdata_o
);
  import csvp_pkg::*;

  logic                                 row_valid;
  logic                                 row_ready;
  logic [LENGTH_BITS-1:0]               row_length;
  logic [FIELD_BITS-1:0]                row_fields;
  logic [LENGTH_BITS-1:0]               res_length;
  logic [FIELD_BITS-1:0]                res_fields;
  logic                                 length_hit;
  logic                                 fields_hit;
  logic                                 realloc_needed;
  logic [LENGTH_BITS+FRACTION_BITS-1:0] predicted_length;
  logic [FIELD_BITS+FRACTION_BITS-1:0]  predicted_fields;
  logic [COUNT_BITS-1:0]                rows_seen;
  logic [COUNT_BITS-1:0]                length_hits_total;
  logic [COUNT_BITS-1:0]                fields_hits_total;
  logic [COUNT_BITS-1:0]                allocs_predicted;
  logic [COUNT_BITS-1:0]                allocs_naive;
  logic [OUT_BITS-1:0]                  res_packed;

  csvp_scanner #(
    .LENGTH_BITS (LENGTH_BITS),
    .FIELD_BITS  (FIELD_BITS)
  ) u_scanner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_o   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .s_tlast_i    (s_tlast_i),
    .row_valid_o  (row_valid),
    .row_ready_i  (row_ready),
    .row_length_o (row_length),
    .row_fields_o (row_fields)
  );

  csvp_predictor #(
    .LENGTH_BITS   (LENGTH_BITS),
    .FIELD_BITS    (FIELD_BITS),
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_predictor (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .row_valid_i         (row_valid),
    .row_ready_o         (row_ready),
    .row_length_i        (row_length),
    .row_fields_i        (row_fields),
    .out_valid_o         (m_tvalid_o),
    .out_ready_i         (m_tready_i),
    .row_length_o        (res_length),
    .row_fields_o        (res_fields),
    .length_hit_o        (length_hit),
    .fields_hit_o        (fields_hit),
    .realloc_needed_o    (realloc_needed),
    .predicted_length_o  (predicted_length),
    .predicted_fields_o  (predicted_fields),
    .rows_seen_o         (rows_seen),
    .length_hits_total_o (length_hits_total),
    .fields_hits_total_o (fields_hits_total),
    .allocs_predicted_o  (allocs_predicted),
    .allocs_naive_o      (allocs_naive)
  );

  // Pack the result beat, first field lowest
  assign res_packed = {allocs_naive, allocs_predicted, fields_hits_total, length_hits_total,
                       rows_seen, predicted_fields, predicted_length, realloc_needed,
                       fields_hit, length_hit, res_fields, res_length};
  assign m_tdata_o  = OUT_W'(res_packed);

`ifndef SYNTH
  // Input stalls only when both the row register and the result register are full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> (m_tvalid_o && !m_tready_i))
    else $error("input stalled while the result path had room");

  // Row total never goes backward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (rows_seen >= $past(rows_seen)))
    else $error("rows_seen decreased");

  // Every row costs at least one predicted allocation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    allocs_predicted >= rows_seen)
    else $error("allocs_predicted below rows_seen");

  // Hits are scored at most once per row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (length_hits_total <= rows_seen) && (fields_hits_total <= rows_seen))
    else $error("hit total exceeds rows_seen");
`endif

endmodule

// ===== hw/rtl/csvp_scanner.sv =====
// Byte scanner: quote tracking, field and length counting, row event register.
`timescale 1ns / 1ps

module csvp_scanner #(
  parameter int unsigned LENGTH_BITS = csvp_pkg::LENGTH_BITS_DEF,
  parameter int unsigned FIELD_BITS  = csvp_pkg::FIELD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [csvp_pkg::BYTE_BITS-1:0] s_tdata_i,
  input  logic                           s_tlast_i,
  output logic                           row_valid_o,
  input  logic                           row_ready_i,
  output logic [LENGTH_BITS-1:0]         row_length_o,
  output logic [FIELD_BITS-1:0]          row_fields_o
);
  import csvp_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [FIELD_BITS-1:0]  FLD_MAX = {FIELD_BITS{1'b1}};
  localparam logic [FIELD_BITS-1:0]  FLD_ONE = FIELD_BITS'(1);

  logic                   quote_q, quote_d;
  logic                   cr_q, cr_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [FIELD_BITS-1:0]  fld_q, fld_d;
  logic                   row_valid_q;
  logic [LENGTH_BITS-1:0] row_len_q;
  logic [FIELD_BITS-1:0]  row_fld_q;

  logic                   accept;
  logic                   row_done;
  logic                   emit;
  logic [LENGTH_BITS-1:0] emit_len;
  logic [FIELD_BITS-1:0]  emit_fld;

  assign s_tready_o = !row_valid_q || row_ready_i;
  assign accept     = s_tvalid_i && s_tready_o;

  // Classify the byte and work out the next row state
  always_comb begin
    quote_d  = quote_q;
    cr_d     = cr_q;
    len_d    = len_q;
    fld_d    = fld_q;
    row_done = 1'b0;
    emit     = 1'b0;
    emit_len = len_q;
    emit_fld = fld_q;

    if (s_tdata_i == CHAR_QUOTE) begin
      quote_d = !quote_q;
    end else if (!quote_q) begin
      if (s_tdata_i == CHAR_COMMA) begin
        fld_d = (fld_q == FLD_MAX) ? FLD_MAX : fld_q + FLD_ONE;
      end else if (s_tdata_i == CHAR_LF) begin
        row_done = 1'b1;
        emit     = 1'b1;
        // drop a carriage return that sits right before the newline
        emit_len = (cr_q && (len_q != '0)) ? len_q - LENGTH_BITS'(1) : len_q;
      end
    end

    if (row_done) begin
      cr_d  = 1'b0;
      len_d = '0;
      fld_d = FLD_ONE;
    end else begin
      len_d = (len_q == LEN_MAX) ? LEN_MAX : len_q + LENGTH_BITS'(1);
      cr_d  = (s_tdata_i == CHAR_CR);
      // flush the open row on the final byte
      if (s_tlast_i) begin
        emit     = 1'b1;
        emit_len = len_d;
        emit_fld = fld_d;
      end
    end

    if (s_tlast_i) begin
      quote_d = 1'b0;
      cr_d    = 1'b0;
      len_d   = '0;
      fld_d   = FLD_ONE;
    end
  end

  // Hold scanner state and the row event flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q     <= 1'b0;
      cr_q        <= 1'b0;
      len_q       <= '0;
      fld_q       <= FLD_ONE;
      row_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        quote_q <= quote_d;
        cr_q    <= cr_d;
        len_q   <= len_d;
        fld_q   <= fld_d;
      end
      if (accept && emit) begin
        row_valid_q <= 1'b1;
      end else if (row_ready_i) begin
        row_valid_q <= 1'b0;
      end
    end
  end

  // Load the row payload
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      row_len_q <= emit_len;
      row_fld_q <= emit_fld;
    end
  end

  assign row_valid_o  = row_valid_q;
  assign row_length_o = row_len_q;
  assign row_fields_o = row_fld_q;

endmodule

// ===== hw/rtl/csvp_predictor.sv =====
// Row scoring, EWMA prediction update, running totals and the result register.
`timescale 1ns / 1ps

module csvp_predictor #(
  parameter int unsigned LENGTH_BITS   = csvp_pkg::LENGTH_BITS_DEF,
  parameter int unsigned FIELD_BITS    = csvp_pkg::FIELD_BITS_DEF,
  parameter int unsigned COUNT_BITS    = csvp_pkg::COUNT_BITS_DEF,
  parameter int unsigned FRACTION_BITS = csvp_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [csvp_pkg::ALPHA_BITS-1:0]       cfg_wdata_i,
  input  logic                                  row_valid_i,
  output logic                                  row_ready_o,
  input  logic [LENGTH_BITS-1:0]                row_length_i,
  input  logic [FIELD_BITS-1:0]                 row_fields_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [LENGTH_BITS-1:0]                row_length_o,
  output logic [FIELD_BITS-1:0]                 row_fields_o,
  output logic                                  length_hit_o,
  output logic                                  fields_hit_o,
  output logic                                  realloc_needed_o,
  output logic [LENGTH_BITS+FRACTION_BITS-1:0]  predicted_length_o,
  output logic [FIELD_BITS+FRACTION_BITS-1:0]   predicted_fields_o,
  output logic [COUNT_BITS-1:0]                 rows_seen_o,
  output logic [COUNT_BITS-1:0]                 length_hits_total_o,
  output logic [COUNT_BITS-1:0]                 fields_hits_total_o,
  output logic [COUNT_BITS-1:0]                 allocs_predicted_o,
  output logic [COUNT_BITS-1:0]                 allocs_naive_o
);
  import csvp_pkg::*;

  localparam int unsigned LE_W = LENGTH_BITS + FRACTION_BITS;
  localparam int unsigned FE_W = FIELD_BITS + FRACTION_BITS;
  localparam int unsigned LP_W = LE_W + ALPHA_BITS + 2;
  localparam int unsigned FP_W = FE_W + ALPHA_BITS + 2;
  localparam int unsigned SN_W = ((COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [LE_W-1:0] LEN_EST_RESET = LE_W'(LENGTH_SEED) << FRACTION_BITS;
  localparam logic [FE_W-1:0] FLD_EST_RESET = FE_W'(FIELDS_SEED) << FRACTION_BITS;

  logic [ALPHA_BITS-1:0] alpha_q;
  logic [LE_W-1:0]       len_est_q, len_est_d;
  logic [FE_W-1:0]       fld_est_q, fld_est_d;
  logic                  seen_q;
  logic [COUNT_BITS-1:0] rows_q, rows_d;
  logic [COUNT_BITS-1:0] lhits_q, lhits_d;
  logic [COUNT_BITS-1:0] fhits_q, fhits_d;
  logic [COUNT_BITS-1:0] aw_q, aw_d;
  logic [COUNT_BITS-1:0] an_q, an_d;
  logic                  out_valid_q;
  logic [LENGTH_BITS-1:0] out_len_q;
  logic [FIELD_BITS-1:0]  out_fld_q;
  logic                   out_lhit_q, out_fhit_q, out_realloc_q;

  logic                  take;
  logic [ALPHA_BITS-1:0] alpha_eff;
  logic [LE_W-1:0]       len_x;
  logic [FE_W-1:0]       fld_x;
  logic [LE_W+2:0]       len_x5, len_e6, diff5, hit_limit;
  logic [LE_W-1:0]       len_diff;
  logic [FIELD_BITS:0]   fld_round;
  logic [FE_W:0]         fld_round_sum;
  logic                  realloc, lhit, fhit;
  logic signed [LE_W:0]  len_delta;
  logic signed [FE_W:0]  fld_delta;
  logic signed [LP_W-1:0] len_prod, len_rnd;
  logic signed [FP_W-1:0] fld_prod, fld_rnd;
  logic [LE_W-1:0]       len_blend;
  logic [FE_W-1:0]       fld_blend;
  logic [COUNT_BITS:0]   aw_sum;
  logic [SN_W-1:0]       an_sum;

  assign row_ready_o = !out_valid_q || out_ready_i;
  assign take        = row_valid_i && row_ready_o;
  assign alpha_eff   = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign len_x       = {row_length_i, {FRACTION_BITS{1'b0}}};
  assign fld_x       = {row_fields_i, {FRACTION_BITS{1'b0}}};

  // Score the old predictions
  always_comb begin
    len_x5    = (LE_W+3)'(len_x) + ((LE_W+3)'(len_x) << 2);
    len_e6    = ((LE_W+3)'(len_est_q) << 2) + ((LE_W+3)'(len_est_q) << 1);
    realloc   = len_x5 > len_e6;
    len_diff  = (len_x > len_est_q) ? len_x - len_est_q : len_est_q - len_x;
    diff5     = (LE_W+3)'(len_diff) + ((LE_W+3)'(len_diff) << 2);
    hit_limit = ((LE_W+3)'(row_length_i) + (LE_W+3)'(1)) << FRACTION_BITS;
    lhit      = seen_q && (diff5 < hit_limit);
    fld_round_sum = (FE_W+1)'(fld_est_q) + ((FE_W+1)'(1) << (FRACTION_BITS - 1));
    fld_round = fld_round_sum[FE_W:FRACTION_BITS];
    fhit      = seen_q && (fld_round == {1'b0, row_fields_i});
  end

  // Blend as E + a*(X - E), rounded to nearest in the alpha scale; the first row loads X
  always_comb begin
    len_delta = $signed({1'b0, len_x}) - $signed({1'b0, len_est_q});
    fld_delta = $signed({1'b0, fld_x}) - $signed({1'b0, fld_est_q});
    len_prod  = len_delta * $signed({1'b0, alpha_eff});
    fld_prod  = fld_delta * $signed({1'b0, alpha_eff});
    len_rnd   = len_prod + LP_W'(ALPHA_HALF);
    fld_rnd   = fld_prod + FP_W'(ALPHA_HALF);
    len_blend = len_est_q + LE_W'(len_rnd >>> ALPHA_SHIFT);
    fld_blend = fld_est_q + FE_W'(fld_rnd >>> ALPHA_SHIFT);
    len_est_d = seen_q ? len_blend : len_x;
    fld_est_d = seen_q ? fld_blend : fld_x;
  end

  // Advance the saturating totals
  always_comb begin
    rows_d  = (rows_q == CNT_MAX) ? CNT_MAX : rows_q + COUNT_BITS'(1);
    lhits_d = (lhit && (lhits_q != CNT_MAX)) ? lhits_q + COUNT_BITS'(1) : lhits_q;
    fhits_d = (fhit && (fhits_q != CNT_MAX)) ? fhits_q + COUNT_BITS'(1) : fhits_q;
    aw_sum  = (COUNT_BITS+1)'(aw_q) + (realloc ? (COUNT_BITS+1)'(2) : (COUNT_BITS+1)'(1));
    aw_d    = (aw_sum > (COUNT_BITS+1)'(CNT_MAX)) ? CNT_MAX : aw_sum[COUNT_BITS-1:0];
    an_sum  = SN_W'(an_q) + SN_W'(row_fields_i);
    an_d    = (an_sum > SN_W'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(an_sum);
  end

  // Hold alpha, predictions, totals and the result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= ALPHA_RESET;
      len_est_q   <= LEN_EST_RESET;
      fld_est_q   <= FLD_EST_RESET;
      seen_q      <= 1'b0;
      rows_q      <= '0;
      lhits_q     <= '0;
      fhits_q     <= '0;
      aw_q        <= '0;
      an_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        alpha_q <= cfg_wdata_i;
      end
      if (take) begin
        len_est_q   <= len_est_d;
        fld_est_q   <= fld_est_d;
        seen_q      <= 1'b1;
        rows_q      <= rows_d;
        lhits_q     <= lhits_d;
        fhits_q     <= fhits_d;
        aw_q        <= aw_d;
        an_q        <= an_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the per-row result fields
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_len_q     <= row_length_i;
      out_fld_q     <= row_fields_i;
      out_lhit_q    <= lhit;
      out_fhit_q    <= fhit;
      out_realloc_q <= realloc;
    end
  end

  // Totals and predictions change only with a new result, so they read out directly
  assign out_valid_o         = out_valid_q;
  assign row_length_o        = out_len_q;
  assign row_fields_o        = out_fld_q;
  assign length_hit_o        = out_lhit_q;
  assign fields_hit_o        = out_fhit_q;
  assign realloc_needed_o    = out_realloc_q;
  assign predicted_length_o  = len_est_q;
  assign predicted_fields_o  = fld_est_q;
  assign rows_seen_o         = rows_q;
  assign length_hits_total_o = lhits_q;
  assign fields_hits_total_o = fhits_q;
  assign allocs_predicted_o  = aw_q;
  assign allocs_naive_o      = an_q;

endmodule
